@@ rtl/r2fft_pkg.sv @@
// Package for the radix-2 DIT FFT: shared types, constants and twiddle table.
// No dependencies.
package r2fft_pkg;

  localparam int DataW = 23;
  localparam int TwW   = 16;
  localparam logic signed [DataW-1:0] VMax = 23'sh3FFFFF;
  localparam logic signed [DataW-1:0] VMin = -23'sh400000;

  localparam logic [0:0] RegLog2 = 1'b0;
  localparam logic [0:0] RegInv  = 1'b1;

  typedef struct packed {
    logic       ld_wr;     // write input sample
    logic       bf_rd;     // read butterfly operands
    logic       bf_wr;     // write butterfly results
    logic       sc_rd;     // read for output
    logic       inv;       // inverse mode
  } r2fft_cmd_t;

  // round(32768*cos(k*pi/32)), k = 0..16, cos(0) saturated
  function automatic logic signed [TwW-1:0] qcos(input logic [4:0] k);
    logic signed [TwW-1:0] r;
    case (k)
      5'd0:  r = 16'sd32767;  5'd1:  r = 16'sd32610;  5'd2:  r = 16'sd32138;
      5'd3:  r = 16'sd31357;  5'd4:  r = 16'sd30274;  5'd5:  r = 16'sd28899;
      5'd6:  r = 16'sd27246;  5'd7:  r = 16'sd25330;  5'd8:  r = 16'sd23170;
      5'd9:  r = 16'sd20788;  5'd10: r = 16'sd18205;  5'd11: r = 16'sd15447;
      5'd12: r = 16'sd12540;  5'd13: r = 16'sd9512;   5'd14: r = 16'sd6393;
      5'd15: r = 16'sd3212;
      default: r = 16'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [DataW-1:0] sat23(input logic signed [DataW+1:0] v);
    logic signed [DataW-1:0] r;
    if (v > 25'(VMax)) r = VMax;
    else if (v < 25'(VMin)) r = VMin;
    else r = v[DataW-1:0];
    return r;
  endfunction

endpackage

@@ rtl/r2fft_ctrl.sv @@
// Controller for the radix-2 DIT FFT: load, butterfly schedule, output.
// Depends on r2fft_pkg.
module r2fft_ctrl import r2fft_pkg::*; #(
  parameter int AW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [2:0]    lg_i,
  input  logic          inv_i,
  input  logic          clr_i,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  input  logic          out_free_i,
  output r2fft_cmd_t    cmd_o,
  output logic [AW-1:0] addr_p_o,
  output logic [AW-1:0] addr_q_o,
  output logic [4:0]    tw_k_o,
  output logic [2:0]    sh_o,
  output logic          last_o
);

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_RD   = 4'b0010,
    S_WR   = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [AW:0]   cnt_q, cnt_d;     // load index / output index
  logic [AW-1:0] bf_q, bf_d;       // butterfly index within stage
  logic [2:0]    st_q, st_d;       // stage 1..lg
  logic          inv_q, inv_d;
  logic [AW:0]   n;
  logic [AW-1:0] rev, half_m, grp, j;
  logic          acc;

  assign n = (AW+1)'(1) << lg_i;
  assign acc = s_tvalid_i && s_tready_o;
  assign s_tready_o = (state_q == S_LOAD);

  always_comb begin
    rev = '0;
    for (int t = 0; t < AW; t++) begin
      if (t < int'(lg_i)) rev[t] = cnt_q[int'(lg_i) - 1 - t];
    end
  end

  // butterfly b in stage st: j = b mod half, grp = b with its low bits cleared (b - j)
  assign half_m = AW'((AW+1)'(1) << (st_q - 3'd1)) - AW'(1);
  assign j      = bf_q & half_m;
  assign grp    = bf_q & ~half_m;
  assign addr_p_o = (state_q == S_LOAD) ? rev :
                    (state_q == S_OUT) ? cnt_q[AW-1:0] : ((grp << 1) | j);
  assign addr_q_o = addr_p_o | (half_m + AW'(1));
  assign tw_k_o   = 5'((6'(j) << (3'd6 - st_q)) & 6'h1F);
  assign sh_o     = lg_i;
  assign last_o   = (cnt_q == n - (AW+1)'(1));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bf_d    = bf_q;
    st_d    = st_q;
    inv_d   = inv_q;
    cmd_o   = '0;
    cmd_o.inv = inv_q;
    case (state_q)
      S_LOAD: begin
        if (acc) begin
          cmd_o.ld_wr = 1'b1;
          if (cnt_q + (AW+1)'(1) >= n) begin
            cnt_d = '0;
            bf_d  = '0;
            st_d  = 3'd1;
            inv_d = inv_i;
            state_d = (lg_i == 3'd0) ? S_OUT : S_RD;
          end else begin
            cnt_d = cnt_q + (AW+1)'(1);
          end
        end
      end
      S_RD: begin
        cmd_o.bf_rd = 1'b1;
        state_d = S_WR;
      end
      S_WR: begin
        cmd_o.bf_wr = 1'b1;
        if ((AW+1)'(bf_q) + (AW+1)'(1) >= (n >> 1)) begin
          bf_d = '0;
          if (st_q >= lg_i) state_d = S_OUT;
          else begin
            st_d = st_q + 3'd1;
            state_d = S_RD;
          end
        end else begin
          bf_d = bf_q + AW'(1);
          state_d = S_RD;
        end
      end
      S_OUT: begin
        if (out_free_i) begin
          cmd_o.sc_rd = 1'b1;
          if (last_o) begin
            cnt_d = '0;
            state_d = S_LOAD;
          end else begin
            cnt_d = cnt_q + (AW+1)'(1);
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
    if (clr_i) cnt_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      bf_q    <= '0;
      st_q    <= 3'd1;
      inv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bf_q    <= bf_d;
      st_q    <= st_d;
      inv_q   <= inv_d;
    end
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_rd_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RD |=> state_q == S_WR) else $error("read not followed by write");
  a_no_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_LOAD |-> !s_tready_o) else $error("ready while busy");

endmodule

@@ rtl/r2fft_dp.sv @@
// Datapath for the radix-2 DIT FFT: sample memory, butterfly, output register.
// Depends on r2fft_pkg.
module r2fft_dp import r2fft_pkg::*; #(
  parameter int AW = 6,
  parameter int SW = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  r2fft_cmd_t              cmd_i,
  input  logic [AW-1:0]           addr_p_i,
  input  logic [AW-1:0]           addr_q_i,
  input  logic [4:0]              tw_k_i,
  input  logic [2:0]              sh_i,
  input  logic                    last_i,
  input  logic signed [SW-1:0]    in_re_i,
  input  logic signed [SW-1:0]    in_im_i,
  output logic                    out_free_o,
  output logic                    m_tvalid_o,
  input  logic                    m_tready_i,
  output logic signed [DataW-1:0] out_re_o,
  output logic signed [DataW-1:0] out_im_o,
  output logic                    out_last_o
);

  localparam int Depth = 1 << AW;
  localparam int PW = DataW + TwW + 2;

  logic signed [DataW-1:0] mem_re [Depth];
  logic signed [DataW-1:0] mem_im [Depth];
  logic signed [DataW-1:0] ur_q, ui_q, xr_q, xi_q;
  logic signed [TwW-1:0]   c, s, s_eff;
  logic signed [PW-1:0]    pr, pi;
  logic signed [DataW-1:0] vr, vi, lre, lim;
  logic [4:0]              k;
  logic                    v_q, v_d;
  logic signed [DataW-1:0] ore_q, oim_q;
  logic                    olast_q;

  assign k = tw_k_i;
  always_comb begin
    if (k <= 5'd16) begin
      c = qcos(k);
      s = qcos(5'd16 - k);
    end else begin
      c = -qcos(5'd0 - k);
      s = qcos(k - 5'd16);
    end
    s_eff = cmd_i.inv ? s : -s;
  end

  assign pr = PW'(xr_q) * PW'(c) - PW'(xi_q) * PW'(s_eff) + PW'(16384);
  assign pi = PW'(xr_q) * PW'(s_eff) + PW'(xi_q) * PW'(c) + PW'(16384);

  function automatic logic signed [DataW-1:0] satp(input logic signed [PW-1:0] v);
    logic signed [PW-16:0] t;
    t = v[PW-1:15];
    if (t > (PW-15)'(VMax)) return VMax;
    if (t < (PW-15)'(VMin)) return VMin;
    return t[DataW-1:0];
  endfunction

  assign vr = satp(pr);
  assign vi = satp(pi);
  assign lre = sat23((DataW+2)'(in_re_i));
  assign lim = sat23((DataW+2)'(in_im_i));

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_wr) begin
      mem_re[addr_p_i] <= lre;
      mem_im[addr_p_i] <= lim;
    end else if (cmd_i.bf_wr) begin
      mem_re[addr_p_i] <= sat23(25'(ur_q) + 25'(vr));
      mem_im[addr_p_i] <= sat23(25'(ui_q) + 25'(vi));
    end
    if (cmd_i.bf_wr) begin
      mem_re[addr_q_i] <= sat23(25'(ur_q) - 25'(vr));
      mem_im[addr_q_i] <= sat23(25'(ui_q) - 25'(vi));
    end
    if (cmd_i.bf_rd) begin
      ur_q <= mem_re[addr_p_i];
      ui_q <= mem_im[addr_p_i];
      xr_q <= mem_re[addr_q_i];
      xi_q <= mem_im[addr_q_i];
    end
    if (cmd_i.sc_rd) begin
      ore_q   <= cmd_i.inv ? (mem_re[addr_p_i] >>> sh_i) : mem_re[addr_p_i];
      oim_q   <= cmd_i.inv ? (mem_im[addr_p_i] >>> sh_i) : mem_im[addr_p_i];
      olast_q <= last_i;
    end
  end

  always_comb begin
    v_d = v_q;
    if (m_tready_i) v_d = 1'b0;
    if (cmd_i.sc_rd) v_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else         v_q <= v_d;
  end

  assign out_free_o = !v_q || m_tready_i;
  assign m_tvalid_o = v_q;
  assign out_re_o   = ore_q;
  assign out_im_o   = oim_q;
  assign out_last_o = olast_q;

  a_no_ovw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sc_rd |-> (!v_q || m_tready_i)) else $error("output overwrite");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.ld_wr && cmd_i.bf_wr)) else $error("write conflict");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q && !m_tready_i |=> v_q) else $error("result dropped");

endmodule

@@ rtl/radix2_dit_fft_top.sv @@
// Channel    | Dir | Payload
// s_axis     | in  | tdata[15:0] sample_re, [31:16] sample_im
// m_axis     | out | tdata[22:0] bin_re, [45:23] bin_im, tuser bin_last
// apb        | in  | 0x0 log2_points, 0x4 inverse_mode
// Loads N samples at one per cycle, then runs (N/2)*log2N butterflies, each a
// shared memory read state then a write state, then emits N results at one per
// cycle unless the output stalls. The input is not ready during the transform
// and output. Output stalls hold the result register.
// Depends on r2fft_pkg, r2fft_ctrl, r2fft_dp.
module radix2_dit_fft_top import r2fft_pkg::*; #(
  parameter int MAX_POINTS   = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [2*SAMPLE_WIDTH-1:0] s_axis_tdata_i,   // sample_re, sample_im
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [47:0]               m_axis_tdata_o,   // bin_re, bin_im, zero pad
  output logic                      m_axis_tuser_o,   // bin_last
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam logic [2:0] MaxLg = 3'(AW);

  logic [2:0] lg_q;
  logic       inv_q, wr, clr;
  logic [2:0] lg_eff;
  r2fft_cmd_t cmd;
  logic [AW-1:0] ap, aq;
  logic [4:0] twk;
  logic [2:0] sh;
  logic last, ofree;
  logic signed [DataW-1:0] ore, oim;

  assign pready = 1'b1;
  assign wr  = psel && penable && pwrite;
  assign clr = wr && (paddr[2] == RegLog2);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_q  <= 3'd3;
      inv_q <= 1'b0;
    end else if (wr) begin
      case (paddr[2])
        RegLog2: lg_q  <= pwdata[2:0];
        RegInv:  inv_q <= pwdata[0];
        default: ;
      endcase
    end
  end
  assign prdata = (paddr[2] == RegInv) ? {31'd0, inv_q} : {29'd0, lg_q};
  assign lg_eff = (lg_q > MaxLg) ? MaxLg : lg_q;

  r2fft_ctrl #(.AW(AW)) u_ctrl (
    .clk_i, .rst_ni, .lg_i(lg_eff), .inv_i(inv_q), .clr_i(clr),
    .s_tvalid_i(s_axis_tvalid_i), .s_tready_o(s_axis_tready_o),
    .out_free_i(ofree), .cmd_o(cmd), .addr_p_o(ap), .addr_q_o(aq),
    .tw_k_o(twk), .sh_o(sh), .last_o(last)
  );

  r2fft_dp #(.AW(AW), .SW(SAMPLE_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .addr_p_i(ap), .addr_q_i(aq), .tw_k_i(twk),
    .sh_i(sh), .last_i(last),
    .in_re_i(s_axis_tdata_i[SAMPLE_WIDTH-1:0]),
    .in_im_i(s_axis_tdata_i[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .out_free_o(ofree), .m_tvalid_o(m_axis_tvalid_o), .m_tready_i(m_axis_tready_i),
    .out_re_o(ore), .out_im_o(oim), .out_last_o(m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {2'b00, oim, ore};

endmodule
